### design/eodh_pkg.sv
// Shared constants, types and register codes for the orbit density histogram.
package eodh_pkg;

  localparam int GRID_COLUMNS   = 1024;
  localparam int GRID_ROWS      = 512;
  localparam int MAX_ITERATIONS = 255;
  localparam int COUNT_BITS     = 32;
  localparam int COL_BITS       = $clog2(GRID_COLUMNS);
  localparam int ROW_BITS       = $clog2(GRID_ROWS);
  localparam int BIN_TOTAL      = GRID_COLUMNS * GRID_ROWS;
  localparam int IDX_BITS       = $clog2(BIN_TOTAL);
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [2:0] REG_X_LOW   = 3'd0;
  localparam logic [2:0] REG_X_HIGH  = 3'd1;
  localparam logic [2:0] REG_Y_LOW   = 3'd2;
  localparam logic [2:0] REG_Y_HIGH  = 3'd3;
  localparam logic [2:0] REG_X_SCALE = 3'd4;
  localparam logic [2:0] REG_Y_SCALE = 3'd5;
  localparam logic [2:0] REG_LIMIT   = 3'd6;

  localparam logic [31:0] RST_X_LOW   = 32'hE000_0000;
  localparam logic [31:0] RST_X_HIGH  = 32'h1000_0000;
  localparam logic [31:0] RST_Y_LOW   = 32'hF000_0000;
  localparam logic [31:0] RST_Y_HIGH  = 32'h1000_0000;
  localparam logic [31:0] RST_X_SCALE = 32'd22347776;
  localparam logic [31:0] RST_Y_SCALE = 32'd16744448;
  localparam logic [7:0]  RST_LIMIT   = 8'd255;

  localparam logic [63:0] ESCAPE_RADIUS_SQ = 64'h0400_0000_0000_0000;

  typedef enum logic {
    OP_TRACE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic signed [31:0]  c_real;
    logic signed [31:0]  c_imag;
    logic [9:0]          read_column;
    logic [8:0]          read_row;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic pop;
    logic clear_done;
  } engine_status_t;

endpackage

### design/escape_orbit_density_histogram_unit.sv
// Top level of the escape orbit density histogram.
// A trace item (tuser 0) runs the orbit of c once for the escape test, stepping
// through P1_MUL and P1_ADV, and, only for an escaping point, once more through
// P2_MUL, P2_ADV and P2_INC while bins are updated. A read item (tuser 1) passes
// through RD_ISSUE and RD_WAIT. After reset the histogram is cleared one bin a
// cycle and no item is accepted until that sweep ends; configuration writes are
// taken throughout.
module escape_orbit_density_histogram_unit import eodh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // c_real, c_imag, read_column, read_row, zero fill
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // escaped, hit_count, bin_value, zero fill
);

  queue_head_t    head;
  engine_status_t status;

  eodh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .status   (status),
    .head     (head)
  );

  eodh_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

### design/eodh_front.sv
// Input stage: accepts transfers, decodes the command and queues items.
module eodh_front import eodh_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [87:0]    s_tdata,
  input  logic           s_tuser,
  input  engine_status_t status,
  output queue_head_t    head
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  item_t               slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   fill;
  item_t               incoming;
  logic                push;
  logic                pop;

  always_comb begin
    incoming.op          = s_tuser ? OP_READ : OP_TRACE;
    incoming.c_real      = s_tdata[31:0];
    incoming.c_imag      = s_tdata[63:32];
    incoming.read_column = s_tdata[73:64];
    incoming.read_row    = s_tdata[82:74];
  end

  assign s_tready   = status.clear_done && (fill != (PTR_BITS+1)'(QUEUE_DEPTH));
  assign push       = s_tvalid && s_tready;
  assign pop        = status.pop && (fill != '0);
  assign head.valid = (fill != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
    end
  end

endmodule

### design/eodh_engine.sv
// Orbit engine: iterates points, updates the histogram memory, serves reads.
module eodh_engine import eodh_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  queue_head_t    head,
  output engine_status_t status,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [47:0]    m_tdata
);

  typedef enum logic [3:0] {
    CLEAR, IDLE, P1_MUL, P1_ADV, P2_MUL, P2_ADV, P2_INC, RD_ISSUE, RD_WAIT, DONE
  } state_t;

  state_t state;

  logic signed [31:0] x_low, x_high, y_low, y_high;
  logic [31:0]        x_scale, y_scale;
  logic [7:0]         limit_reg;

  logic [COUNT_BITS-1:0] mem [BIN_TOTAL];
  logic [COUNT_BITS-1:0] rd_data;
  logic [IDX_BITS-1:0]   clr_addr;
  logic [IDX_BITS-1:0]   idx;

  item_t              cur;
  logic signed [31:0] zr, zi;
  logic signed [63:0] xx, yy, xy;
  logic [63:0]        bx, by;
  logic               in_window;
  logic               ovf;
  logic [7:0]         n;
  logic [7:0]         hits;
  logic [7:0]         lim;
  logic               esc_flag;
  logic [31:0]        bin_count;

  logic               res_escaped;
  logic [7:0]         res_hits;
  logic [31:0]        res_value;

  logic signed [64:0] sq_diff;
  logic signed [36:0] re_next, im_next;
  logic               adv_ovf;
  logic [63:0]        mag;
  logic               escape_now;
  logic [21:0]        col_round, row_round;
  logic [20:0]        col_raw, row_raw;
  logic [COL_BITS-1:0] col_bin;
  logic [ROW_BITS-1:0] row_bin;
  logic [IDX_BITS-1:0] bin_idx;
  logic [31:0]         dx, dy;
  logic                in_now;
  logic [IDX_BITS-1:0] rd_idx;
  logic                rd_in_grid;
  logic [COUNT_BITS-1:0] incr;

  always_comb begin
    priority if (limit_reg == 8'd0) begin
      lim = 8'd1;
    end else if (limit_reg > 8'(MAX_ITERATIONS)) begin
      lim = 8'(MAX_ITERATIONS);
    end else begin
      lim = limit_reg;
    end
  end

  always_comb begin
    sq_diff    = {xx[63], xx} - {yy[63], yy};
    re_next    = sq_diff[64:28] + {{5{cur.c_real[31]}}, cur.c_real};
    im_next    = xy[63:27] + {{5{cur.c_imag[31]}}, cur.c_imag};
    adv_ovf    = !((re_next[36:31] == '0) || (re_next[36:31] == '1)) ||
                 !((im_next[36:31] == '0) || (im_next[36:31] == '1));
    mag        = 64'(xx) + 64'(yy);
    escape_now = mag > ESCAPE_RADIUS_SQ;
    in_now     = (zr >= x_low) && (zr <= x_high) && (zi >= y_low) && (zi <= y_high);
    dx         = 32'(zr - x_low);
    dy         = 32'(zi - y_low);
    col_round  = {1'b0, bx[63:43]} + 22'd1;
    row_round  = {1'b0, by[63:43]} + 22'd1;
    col_raw    = col_round[21:1];
    row_raw    = row_round[21:1];
    col_bin    = (col_raw > 21'(GRID_COLUMNS - 1)) ? COL_BITS'(GRID_COLUMNS - 1)
                                                   : col_raw[COL_BITS-1:0];
    row_bin    = (row_raw > 21'(GRID_ROWS - 1)) ? ROW_BITS'(GRID_ROWS - 1)
                                                : row_raw[ROW_BITS-1:0];
    bin_idx    = IDX_BITS'(row_bin * GRID_COLUMNS) + IDX_BITS'(col_bin);
    rd_in_grid = (32'(cur.read_column) < 32'(GRID_COLUMNS)) &&
                 (32'(cur.read_row) < 32'(GRID_ROWS));
    rd_idx     = IDX_BITS'(32'(cur.read_row) * GRID_COLUMNS) + IDX_BITS'(cur.read_column);
    incr       = (rd_data == '1) ? rd_data : rd_data + 1'b1;
  end

  assign status.pop        = (state == IDLE) && head.valid;
  assign status.clear_done = (state != CLEAR);
  assign m_tdata           = {7'd0, res_value, res_hits, res_escaped};

  always_ff @(posedge clk) begin
    if (state == CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (state == P2_INC && in_window) begin
      mem[idx] <= incr;
    end
    if (state == P2_ADV) begin
      rd_data <= mem[bin_idx];
    end else if (state == RD_ISSUE) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low     <= RST_X_LOW;
      x_high    <= RST_X_HIGH;
      y_low     <= RST_Y_LOW;
      y_high    <= RST_Y_HIGH;
      x_scale   <= RST_X_SCALE;
      y_scale   <= RST_Y_SCALE;
      limit_reg <= RST_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_LOW:   x_low     <= cfg_data;
        REG_X_HIGH:  x_high    <= cfg_data;
        REG_Y_LOW:   y_low     <= cfg_data;
        REG_Y_HIGH:  y_high    <= cfg_data;
        REG_X_SCALE: x_scale   <= cfg_data;
        REG_Y_SCALE: y_scale   <= cfg_data;
        REG_LIMIT:   limit_reg <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_BITS'(BIN_TOTAL - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (head.valid) begin
            cur       <= head.item;
            zr        <= '0;
            zi        <= '0;
            ovf       <= 1'b0;
            n         <= 8'd1;
            hits      <= '0;
            esc_flag  <= 1'b0;
            bin_count <= '0;
            state     <= (head.item.op == OP_READ) ? RD_ISSUE : P1_MUL;
          end
        end
        P1_MUL: begin
          xx    <= zr * zr;
          yy    <= zi * zi;
          xy    <= zr * zi;
          state <= P1_ADV;
        end
        P1_ADV: begin
          if (n >= lim) begin
            esc_flag <= escape_now;
            if (escape_now) begin
              zr    <= '0;
              zi    <= '0;
              n     <= '0;
              state <= P2_MUL;
            end else begin
              state <= DONE;
            end
          end else if (adv_ovf) begin
            esc_flag <= 1'b1;
            zr       <= '0;
            zi       <= '0;
            n        <= '0;
            state    <= P2_MUL;
          end else begin
            zr    <= re_next[31:0];
            zi    <= im_next[31:0];
            n     <= n + 1'b1;
            state <= P1_MUL;
          end
        end
        P2_MUL: begin
          xx        <= zr * zr;
          yy        <= zi * zi;
          xy        <= zr * zi;
          bx        <= dx * x_scale;
          by        <= dy * y_scale;
          in_window <= in_now;
          state     <= P2_ADV;
        end
        P2_ADV: begin
          ovf   <= adv_ovf;
          zr    <= re_next[31:0];
          zi    <= im_next[31:0];
          idx   <= bin_idx;
          state <= P2_INC;
        end
        P2_INC: begin
          if (in_window) begin
            hits <= hits + 1'b1;
          end
          n <= n + 1'b1;
          if (ovf || (n + 1'b1 == lim)) begin
            state <= DONE;
          end else begin
            state <= P2_MUL;
          end
        end
        RD_ISSUE: begin
          state <= RD_WAIT;
        end
        RD_WAIT: begin
          bin_count <= rd_in_grid ? 32'(rd_data) : '0;
          state     <= DONE;
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            res_escaped <= esc_flag;
            res_hits    <= hits;
            res_value   <= bin_count;
            m_tvalid    <= 1'b1;
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### design/eodh_checker.sv
// Port-level assertions for the orbit density histogram and their bind.
module eodh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("ready or valid after reset");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[40:9] != 32'd0) |-> (m_tdata[8:0] == 9'd0))
    else $error("read result carries trace fields");

  a_hits_escaped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[8:1] != 8'd0) |-> m_tdata[0])
    else $error("hits without escape");

endmodule

bind escape_orbit_density_histogram_unit eodh_checker u_eodh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### test/escape_orbit_density_histogram_unit_tb.sv
// Self-checking testbench: orbit traces and bin reads checked against a local model.
`timescale 1ns / 1ps
module escape_orbit_density_histogram_unit_tb;
  import eodh_pkg::*;

  typedef struct {
    logic       escaped;
    logic [7:0] hits;
    logic [31:0] count;
  } outcome_t;

  typedef struct {
    op_t         op;
    logic [31:0] cr;
    logic [31:0] ci;
    logic [9:0]  col;
    logic [8:0]  row;
    bit          typed;
    outcome_t    want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_X_LOW;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;   // c_real, c_imag, read_column, read_row, zero fill
  logic        s_tuser = 1'b0; // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // escaped, hit_count, bin_value, zero fill

  escape_orbit_density_histogram_unit uut (.*);

  logic signed [31:0] win_x_lo = RST_X_LOW, win_x_hi = RST_X_HIGH;
  logic signed [31:0] win_y_lo = RST_Y_LOW, win_y_hi = RST_Y_HIGH;
  logic [31:0] scale_x = RST_X_SCALE, scale_y = RST_Y_SCALE;
  logic [7:0]  orbit_limit = RST_LIMIT;
  int unsigned density [int];
  int          touched_bins [$];
  outcome_t    pending [$];
  int          errors = 0;
  int          accepted = 0;
  int          burst_left = 0;
  logic        hold_off = 1'b0;
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_pos = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void orbit_step(inout longint zr, inout longint zi, inout bit ovf,
                                     input longint cr, input longint ci);
    longint re, im;
    re = ((zr * zr - zi * zi) >>> 28) + cr;
    im = ((zr * zi) >>> 27) + ci;
    if (re < -64'sd2147483648 || re > 64'sd2147483647 ||
        im < -64'sd2147483648 || im > 64'sd2147483647) begin
      ovf = 1'b1;
      zr = 0;
      zi = 0;
    end else begin
      zr = re;
      zi = im;
    end
  endfunction

  function automatic int bin_of(longint v, longint lo, logic [31:0] scale, int cells);
    logic [63:0] d, p, b;
    d = v - lo;
    p = d * {32'b0, scale};
    b = ((p >> 43) + 64'd1) >> 1;
    return (b > cells - 1) ? cells - 1 : int'(b);
  endfunction

  function automatic outcome_t histogram_step(op_t op, logic [31:0] cr_in, logic [31:0] ci_in,
                                              logic [9:0] col, logic [8:0] row);
    outcome_t r;
    longint cr, ci, zr, zi;
    logic [63:0] mag;
    bit ovf;
    int lim, k;
    r = '{1'b0, 8'd0, 32'd0};
    if (op == OP_READ) begin
      k = int'(row) * GRID_COLUMNS + int'(col);
      if (density.exists(k)) r.count = density[k];
      return r;
    end
    cr = longint'(signed'(cr_in));
    ci = longint'(signed'(ci_in));
    lim = (orbit_limit == 0) ? 1 : int'(orbit_limit);
    if (lim > MAX_ITERATIONS) lim = MAX_ITERATIONS;
    zr = 0;
    zi = 0;
    ovf = 1'b0;
    for (int n = 1; n < lim && !ovf; n++) orbit_step(zr, zi, ovf, cr, ci);
    if (ovf) r.escaped = 1'b1;
    else begin
      mag = zr * zr + zi * zi;
      r.escaped = mag > ESCAPE_RADIUS_SQ;
    end
    if (!r.escaped) return r;
    zr = 0;
    zi = 0;
    ovf = 1'b0;
    for (int n = 0; n < lim && !ovf; n++) begin
      if (zr >= win_x_lo && zr <= win_x_hi && zi >= win_y_lo && zi <= win_y_hi) begin
        k = bin_of(zi, win_y_lo, scale_y, GRID_ROWS) * GRID_COLUMNS +
            bin_of(zr, win_x_lo, scale_x, GRID_COLUMNS);
        if (!density.exists(k)) density[k] = 0;
        if (density[k] != 32'hFFFF_FFFF) density[k]++;
        if (touched_bins.size() < 256) touched_bins.push_back(k);
        r.hits++;
      end
      if (n + 1 < lim) orbit_step(zr, zi, ovf, cr, ci);
    end
    return r;
  endfunction

  task automatic transfer_item(op_t op, logic [31:0] cr, logic [31:0] ci,
                               logic [9:0] col, logic [8:0] row, bit typed, outcome_t want);
    outcome_t got;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 15);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'b0, row, col, ci, cr};
    do @(posedge clk); while (!s_tready);
    accepted++;
    got = histogram_step(op, cr, ci, col, row);
    pending.push_back(typed ? want : got);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_X_LOW:   win_x_lo = val;
      REG_X_HIGH:  win_x_hi = val;
      REG_Y_LOW:   win_y_lo = val;
      REG_Y_HIGH:  win_y_hi = val;
      REG_X_SCALE: scale_x = val;
      REG_Y_SCALE: scale_y = val;
      REG_LIMIT:   orbit_limit = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_window(logic [31:0] xl, logic [31:0] xh, logic [31:0] yl,
                            logic [31:0] yh, logic [31:0] sx, logic [31:0] sy,
                            logic [7:0] lim);
    write_reg(REG_X_LOW, xl);
    write_reg(REG_X_HIGH, xh);
    write_reg(REG_Y_LOW, yl);
    write_reg(REG_Y_HIGH, yh);
    write_reg(REG_X_SCALE, sx);
    write_reg(REG_Y_SCALE, sy);
    write_reg(REG_LIMIT, {24'b0, lim});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(int total);
    logic [31:0] cr, ci;
    int k, pick;
    for (int i = 0; i < total; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if (touched_bins.size() != 0 && $urandom_range(0, 9) < 6) begin
          k = touched_bins[$urandom_range(0, touched_bins.size() - 1)];
          transfer_item(OP_READ, $urandom, $urandom, 10'(k % GRID_COLUMNS),
                        9'(k / GRID_COLUMNS), 1'b0, '{0, 0, 0});
        end else
          transfer_item(OP_READ, $urandom, $urandom, 10'($urandom), 9'($urandom), 1'b0,
                        '{0, 0, 0});
      end else begin
        if (pick < 48) begin
          cr = $urandom;
          ci = $urandom;
        end else begin
          cr = -32'sd590558003 + $urandom_range(0, 751619276);
          ci = -32'sd348966092 + $urandom_range(0, 697932184);
        end
        transfer_item(OP_TRACE, cr, ci, 10'($urandom), 9'($urandom), 1'b0, '{0, 0, 0});
      end
    end
  endtask

  always @(posedge clk) begin
    pat_pos <= (pat_pos + 1) % 16;
    if (pat_pos == 15)
      ready_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
    m_tready <= !hold_off && ready_pat[pat_pos];
  end

  initial begin
    wait (accepted == 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (4000) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, actual %h", $time, m_tdata);
      end else begin
        want = pending.pop_front();
        if (m_tdata[0] !== want.escaped) begin
          errors++;
          $display("%0t: escaped expected %0d actual %0d", $time, want.escaped, m_tdata[0]);
        end
        if (m_tdata[8:1] !== want.hits) begin
          errors++;
          $display("%0t: hit_count expected %0d actual %0d", $time, want.hits, m_tdata[8:1]);
        end
        if (m_tdata[40:9] !== want.count) begin
          errors++;
          $display("%0t: bin_value expected %0d actual %0d", $time, want.count,
                   m_tdata[40:9]);
        end
      end
    end
  end

  plan_row_t plan [10];

  initial begin
    plan = '{
      '{OP_READ,  32'h0,        32'h0,        10'd0,    9'd0,   1, '{0, 0, 0}},
      '{OP_READ,  32'h0,        32'h0,        10'd1023, 9'd511, 1, '{0, 0, 0}},
      '{OP_TRACE, 32'h0,        32'h0,        10'd0,    9'd0,   1, '{0, 0, 0}},
      '{OP_TRACE, 32'h7FFFFFFF, 32'h7FFFFFFF, 10'd1023, 9'd511, 0, '{0, 0, 0}},
      '{OP_TRACE, 32'h80000000, 32'h80000000, 10'd0,    9'd0,   0, '{0, 0, 0}},
      '{OP_TRACE, 32'hE0000000, 32'h00000000, 10'd0,    9'd0,   0, '{0, 0, 0}},
      '{OP_TRACE, 32'hF4000000, 32'h01999999, 10'd0,    9'd0,   0, '{0, 0, 0}},
      '{OP_TRACE, 32'h04CCCCCC, 32'h08000000, 10'd0,    9'd0,   0, '{0, 0, 0}},
      '{OP_TRACE, 32'hDE666666, 32'hFE000000, 10'd0,    9'd0,   0, '{0, 0, 0}},
      '{OP_READ,  32'h0,        32'h0,        10'd683,  9'd256, 0, '{0, 0, 0}}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i])
      transfer_item(plan[i].op, plan[i].cr, plan[i].ci, plan[i].col, plan[i].row,
                    plan[i].typed, plan[i].want);
    drain();

    set_window(RST_X_LOW, RST_X_HIGH, RST_Y_LOW, RST_Y_HIGH, RST_X_SCALE, RST_Y_SCALE, 8'd24);
    random_items(180);
    drain();
    set_window(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
               32'hFFFFFFFF, 32'hFFFFFFFF, 8'd1);
    random_items(180);
    drain();
    set_window(32'hC0000000, 32'h20000000, 32'hD0000000, 32'h30000000,
               32'h0, 32'h0, 8'd255);
    random_items(40);
    drain();
    // low above high on both axes, limit of zero acts as one
    set_window(32'h10000000, 32'hF0000000, 32'h10000000, 32'hF0000000,
               32'h00AAAAAA, 32'h00555555, 8'd0);
    random_items(180);
    drain();
    set_window(-32'sd536870912 - $urandom_range(0, 1 << 28), $urandom_range(0, 1 << 29),
               -32'sd268435456 - $urandom_range(0, 1 << 28), $urandom_range(0, 1 << 29),
               $urandom, $urandom, 8'($urandom_range(2, 40)));
    random_items(180);
    drain();
    set_window(-32'sd536870912 - $urandom_range(0, 1 << 28), $urandom_range(0, 1 << 29),
               -32'sd268435456 - $urandom_range(0, 1 << 28), $urandom_range(0, 1 << 29),
               $urandom_range(1 << 22, 1 << 26), $urandom_range(1 << 22, 1 << 26),
               8'($urandom_range(8, 64)));
    random_items(180);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
